// ----- design/rau_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation codes, status codes, controller command and status structs.
// ----------------------------------------------------------------------------
package rau_pkg;
  localparam int VALUE_BITS = 32;
  localparam int MAG_W = 64;
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0, MODE_SUB = 3'd1, MODE_MUL = 3'd2,
    MODE_DIV = 3'd3, MODE_CMP = 3'd4
  } mode_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GCD_D_INIT, OP_GCD_STEP, OP_DIV_INIT, OP_DIV_STEP,
    OP_SCALE1, OP_SCALE2, OP_COMBINE, OP_PROD, OP_GCD_N_INIT, OP_RED_N,
    OP_RED_D, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic       gcd_done;
    logic       div_done;
    logic [2:0] mode;
    logic       bad_den;
    logic       div_zero;
    logic       num_zero;
  } sts_t;
endpackage
`default_nettype wire

// ----- design/rau_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, shared 64-bit divider and result logic
// Executes one command per cycle: Euclid steps, restoring division bit steps,
// 32x32 products and final range check.
// ----------------------------------------------------------------------------
module rau_datapath (
  input  wire logic            clk,
  input  wire rau_pkg::cmd_t   cmd,
  output rau_pkg::sts_t        sts,
  input  wire logic [2:0]      in_mode,
  input  wire logic [31:0]     in_left_num,
  input  wire logic [31:0]     in_left_den,
  input  wire logic [31:0]     in_right_num,
  input  wire logic [31:0]     in_right_den,
  output logic [31:0]          res_num,
  output logic [30:0]          res_den,
  output logic                 res_eq,
  output logic [1:0]           res_status
);
  import rau_pkg::*;

  logic [2:0]       mode_r;
  logic [31:0]      n1_r, d1_r, n2_r, d2_r;
  logic             s1_r, s2_r, neg_r;
  logic [MAG_W-1:0] a_r, b_r, g_r, t1_r, t2_r, num_r, den_r;
  // restoring divider: quotient/dividend shift register and remainder
  logic [MAG_W-1:0] q_r, rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             gcd_mode_r;

  // result registers
  logic [31:0]      res_num_r, res_num_nxt;
  logic [30:0]      res_den_r, res_den_nxt;
  logic             res_eq_r, res_eq_nxt;
  logic [1:0]       res_status_r, res_status_nxt;

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  logic [MAG_W:0] trial;
  assign trial = {rem_r, q_r[MAG_W-1]} - {1'b0, dvs_r};

  // product operands: multiply n1*n2 / d1*d2, divide and compare n1*d2 / d1*n2
  logic [31:0] num_op, den_op;
  assign num_op = (mode_r == MODE_MUL) ? n2_r : d2_r;
  assign den_op = (mode_r == MODE_MUL) ? d2_r : n2_r;

  logic [MAG_W-1:0] lim;
  assign lim = MAG_W'(1) << (VALUE_BITS - 1);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r <= in_mode;
        n1_r <= mag(in_left_num);  d1_r <= mag(in_left_den);
        n2_r <= mag(in_right_num); d2_r <= mag(in_right_den);
        s1_r <= (in_left_num[31] ^ in_left_den[31]) && in_left_num != 32'd0;
        s2_r <= ((in_right_num[31] ^ in_right_den[31]) && in_right_num != 32'd0)
                ^ (in_mode == MODE_SUB && in_right_num != 32'd0);
      end
      OP_GCD_D_INIT: begin
        a_r <= MAG_W'(d1_r); b_r <= MAG_W'(d2_r);
      end
      OP_GCD_N_INIT: begin
        a_r <= num_r; b_r <= den_r;
      end
      OP_GCD_STEP: begin
        // start a % b on the divider
        q_r <= a_r; rem_r <= '0; dvs_r <= b_r; cnt_r <= '0; gcd_mode_r <= 1'b1;
      end
      OP_DIV_INIT: begin
        // divide a_r (loaded by caller) by g_r
        q_r <= a_r; rem_r <= '0; dvs_r <= g_r; cnt_r <= '0; gcd_mode_r <= 1'b0;
      end
      OP_DIV_STEP: begin
        if (!trial[MAG_W]) begin
          rem_r <= trial[MAG_W-1:0];
          q_r <= {q_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[MAG_W-2:0], q_r[MAG_W-1]};
          q_r <= {q_r[MAG_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + CNT_W'(1);
        // Euclid: once remainder finished, shift pair
        if (cnt_r == CNT_W'(MAG_W - 1) && gcd_mode_r) begin
          a_r <= b_r;
          b_r <= !trial[MAG_W] ? trial[MAG_W-1:0] : {rem_r[MAG_W-2:0], q_r[MAG_W-1]};
        end
      end
      OP_SCALE1: begin
        g_r <= a_r;       // gcd of denominators
        a_r <= MAG_W'(d2_r);
      end
      OP_SCALE2: begin
        t1_r <= q_r;      // d2/g
        a_r <= MAG_W'(d1_r);
      end
      OP_COMBINE: begin
        // q_r = d1/g, t1_r = d2/g
        t2_r <= MAG_W'(n2_r) * MAG_W'(q_r[31:0]);
        t1_r <= MAG_W'(n1_r) * MAG_W'(t1_r[31:0]);
        den_r <= MAG_W'(q_r[31:0]) * MAG_W'(d2_r);
      end
      OP_PROD: begin
        if (mode_r == MODE_ADD || mode_r == MODE_SUB) begin
          if (s1_r == s2_r) begin
            num_r <= t1_r + t2_r; neg_r <= s1_r;
          end else if (t1_r >= t2_r) begin
            num_r <= t1_r - t2_r; neg_r <= s1_r;
          end else begin
            num_r <= t2_r - t1_r; neg_r <= s2_r;
          end
        end else begin
          // compare uses the same pair of cross products
          num_r <= MAG_W'(n1_r) * MAG_W'(num_op);
          den_r <= MAG_W'(d1_r) * MAG_W'(den_op);
          neg_r <= s1_r ^ s2_r;
        end
      end
      OP_RED_N: begin
        g_r <= a_r;       // gcd of result
        a_r <= num_r;
      end
      OP_RED_D: begin
        num_r <= q_r;
        a_r <= den_r;
      end
      default: ;
    endcase
  end

  // result selection, loaded on the finish command
  always_comb begin
    res_num_nxt    = res_num_r;
    res_den_nxt    = res_den_r;
    res_eq_nxt     = res_eq_r;
    res_status_nxt = res_status_r;
    if (cmd.op == OP_FINISH) begin
      res_num_nxt    = '0;
      res_den_nxt    = 31'd1;
      res_eq_nxt     = 1'b0;
      res_status_nxt = ST_OK;
      if (mode_r > MODE_CMP) begin
        res_status_nxt = ST_OK;
      end else if (d1_r == 32'd0 || d2_r == 32'd0) begin
        res_status_nxt = ST_ZERO;
      end else if (mode_r == MODE_CMP) begin
        res_eq_nxt = (num_r == den_r) && (num_r == '0 || s1_r == s2_r);
      end else if (mode_r == MODE_DIV && n2_r == 32'd0) begin
        res_status_nxt = ST_ZERO;
      end else if (num_r == '0) begin
        res_status_nxt = ST_OK;
      end else if (q_r > lim - MAG_W'(1) ||
                   (neg_r ? (num_r > lim) : (num_r > lim - MAG_W'(1)))) begin
        res_status_nxt = ST_OVF;
      end else begin
        res_num_nxt = neg_r ? (32'd0 - num_r[31:0]) : num_r[31:0];
        res_den_nxt = q_r[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_num_r    <= res_num_nxt;
    res_den_r    <= res_den_nxt;
    res_eq_r     <= res_eq_nxt;
    res_status_r <= res_status_nxt;
  end

  assign res_num    = res_num_r;
  assign res_den    = res_den_r;
  assign res_eq     = res_eq_r;
  assign res_status = res_status_r;

  always_comb begin
    sts.gcd_done = (b_r == '0);
    sts.div_done = (cnt_r == CNT_W'(MAG_W - 1));
    sts.mode     = mode_r;
    sts.bad_den  = (d1_r == 32'd0) || (d2_r == 32'd0);
    sts.div_zero = (n2_r == 32'd0);
    sts.num_zero = (num_r == '0);
  end
endmodule
`default_nettype wire

// ----- design/rau_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Walks GCD, exact division and product steps and handles the handshake.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rau_pkg::cmd_t      cmd,
  input  wire rau_pkg::sts_t sts
);
  import rau_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_GD_INIT, S_GD_START, S_GD_RUN, S_SC1, S_SC1_RUN, S_SC2,
    S_SC2_RUN, S_COMB, S_PROD, S_GN_INIT, S_GN_START, S_GN_RUN, S_RN, S_RN_RUN,
    S_RD, S_RD_RUN, S_RD_DIV, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid) begin cmd.op = OP_LOAD; state_nxt = S_CHECK; end
      S_CHECK: begin
        if (sts.mode > MODE_CMP || sts.bad_den || sts.mode == MODE_CMP ||
            (sts.mode == MODE_DIV && sts.div_zero)) begin
          cmd.op = OP_PROD; state_nxt = S_FIN;
        end else if (sts.mode == MODE_ADD || sts.mode == MODE_SUB) begin
          cmd.op = OP_GCD_D_INIT; state_nxt = S_GD_START;
        end else begin
          cmd.op = OP_PROD; state_nxt = S_GN_INIT;
        end
      end
      S_GD_START: begin
        if (sts.gcd_done) begin cmd.op = OP_SCALE1; state_nxt = S_SC1; end
        else begin cmd.op = OP_GCD_STEP; state_nxt = S_GD_RUN; end
      end
      S_GD_RUN: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_done) state_nxt = S_GD_START;
      end
      S_SC1: begin cmd.op = OP_DIV_INIT; state_nxt = S_SC1_RUN; end
      S_SC1_RUN: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_done) state_nxt = S_SC2;
      end
      S_SC2: begin cmd.op = OP_SCALE2; state_nxt = S_GD_INIT; end
      S_GD_INIT: begin cmd.op = OP_DIV_INIT; state_nxt = S_SC2_RUN; end
      S_SC2_RUN: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_done) state_nxt = S_COMB;
      end
      S_COMB: begin cmd.op = OP_COMBINE; state_nxt = S_PROD; end
      S_PROD: begin cmd.op = OP_PROD; state_nxt = S_GN_INIT; end
      S_GN_INIT: begin
        if (sts.num_zero) state_nxt = S_FIN;
        else begin cmd.op = OP_GCD_N_INIT; state_nxt = S_GN_START; end
      end
      S_GN_START: begin
        if (sts.gcd_done) begin cmd.op = OP_RED_N; state_nxt = S_RN; end
        else begin cmd.op = OP_GCD_STEP; state_nxt = S_GN_RUN; end
      end
      S_GN_RUN: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_done) state_nxt = S_GN_START;
      end
      S_RN: begin cmd.op = OP_DIV_INIT; state_nxt = S_RN_RUN; end
      S_RN_RUN: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_done) state_nxt = S_RD;
      end
      S_RD: begin cmd.op = OP_RED_D; state_nxt = S_RD_RUN; end
      S_RD_RUN: begin
        // restart the divider on the denominator
        cmd.op = OP_DIV_INIT; state_nxt = S_RD_DIV;
      end
      S_RD_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin cmd.op = OP_FINISH; state_nxt = S_OUT; end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= (state_nxt == S_OUT);
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accepted input while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_LOAD |-> !in_stall) else $error("load while busy");
`endif
endmodule
`default_nettype wire

// ----- design/rational_arith_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arith_unit: exact fraction add/sub/mul/div/compare with reduction
//
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    mode, two signed fractions
// out_      output     out_valid / out_stall  reduced fraction, is_equal, status
//
// One item at a time. The shared 64-bit restoring divider runs each Euclid
// iteration or exact division as a setup step and 64 bit steps. Add/sub runs
// the denominator GCD and two scaling divisions before the products; mul/div
// goes to the products at once. Both then reduce by the result GCD unless the
// numerator is zero; errors, compare and unused modes finish after products.
// Reset is synchronous and active low and clears only the sequencer.
// A stalled result holds in the output registers; no new item enters meanwhile.
// ----------------------------------------------------------------------------
module rational_arith_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_mode,
  input  wire logic [31:0] in_left_num,
  input  wire logic [31:0] in_left_den,
  input  wire logic [31:0] in_right_num,
  input  wire logic [31:0] in_right_den,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_result_num,
  output logic [30:0]      out_result_den,
  output logic             out_is_equal,
  output logic [1:0]       out_status
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  rau_datapath u_dp (
    .clk, .cmd, .sts, .in_mode, .in_left_num, .in_left_den, .in_right_num,
    .in_right_den, .res_num(out_result_num), .res_den(out_result_den),
    .res_eq(out_is_equal), .res_status(out_status)
  );
endmodule
`default_nettype wire

// ----- tb/tb_rational_arith_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arith_unit: self-checking bench for the rational arithmetic unit
// A directed table of corner cases is followed by random fractions in every
// mode. Each accepted item is predicted by an exact 64-bit sign/magnitude
// model or its typed row; each transfer is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_rational_arith_unit;
  import rau_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_LIMIT   = 200000;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        eq;
    logic [1:0]  st;
  } ratio_t;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] ln, ld, rn, rd;
    bit          typed;
    ratio_t      res;
  } row_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [2:0]  in_mode;
  logic [31:0] in_left_num, in_left_den, in_right_num, in_right_den;
  logic        out_valid, out_stall;
  logic [31:0] out_result_num;
  logic [30:0] out_result_den;
  logic        out_is_equal;
  logic [1:0]  out_status;

  ratio_t expected_q[$];
  row_t   table_q[$];
  int     errors = 0, accepted = 0, checked = 0, idle_cycles = 0;
  bit     stim_done;

  rational_arith_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --- exact predictor ------------------------------------------------------
  function automatic longint unsigned magnitude(logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
  endfunction

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic ratio_t plain(logic [1:0] st, logic eq);
    ratio_t r;
    r.num = '0;
    r.den = 31'd1;
    r.eq  = eq;
    r.st  = st;
    return r;
  endfunction

  // reduce sign/n/d and range-check against VALUE_BITS
  function automatic ratio_t reduce_fraction(bit neg, longint unsigned n,
                                             longint unsigned d);
    longint unsigned lim, g;
    ratio_t r;
    lim = 64'd1 << (VALUE_BITS - 1);
    if (n == 0) return plain(ST_OK, 1'b0);
    g = gcd64(n, d);
    n = n / g;
    d = d / g;
    if (d > lim - 1 || (neg ? (n > lim) : (n > lim - 1))) return plain(ST_OVF, 1'b0);
    r = plain(ST_OK, 1'b0);
    r.num = neg ? (32'd0 - n[31:0]) : n[31:0];
    r.den = d[30:0];
    return r;
  endfunction

  function automatic ratio_t predict_ratio(logic [2:0] m, logic [31:0] ln,
                                           logic [31:0] ld, logic [31:0] rn,
                                           logic [31:0] rd);
    longint unsigned n1, d1, n2, d2, g, t1, t2;
    bit s1, s2;
    n1 = magnitude(ln);
    d1 = magnitude(ld);
    n2 = magnitude(rn);
    d2 = magnitude(rd);
    s1 = (ln[31] != ld[31]) && n1 != 0;
    s2 = (rn[31] != rd[31]) && n2 != 0;
    if (m > MODE_CMP) return plain(ST_OK, 1'b0);
    if (d1 == 0 || d2 == 0) return plain(ST_ZERO, 1'b0);
    case (m)
      MODE_ADD, MODE_SUB: begin
        if (m == MODE_SUB && n2 != 0) s2 = !s2;
        g  = gcd64(d1, d2);
        t1 = n1 * (d2 / g);
        t2 = n2 * (d1 / g);
        if (s1 == s2) return reduce_fraction(s1, t1 + t2, (d1 / g) * d2);
        if (t1 >= t2) return reduce_fraction(s1, t1 - t2, (d1 / g) * d2);
        return reduce_fraction(s2, t2 - t1, (d1 / g) * d2);
      end
      MODE_MUL: return reduce_fraction(s1 != s2, n1 * n2, d1 * d2);
      MODE_DIV: begin
        if (n2 == 0) return plain(ST_ZERO, 1'b0);
        return reduce_fraction(s1 != s2, n1 * d2, d1 * n2);
      end
      default: begin
        t1 = n1 * d2;
        t2 = n2 * d1;
        return plain(ST_OK, (t1 == t2 && (t1 == 0 || s1 == s2)));
      end
    endcase
  endfunction

  // --- stimulus table ---------------------------------------------------------
  task automatic add_row(logic [2:0] m, logic [31:0] ln, logic [31:0] ld,
                         logic [31:0] rn, logic [31:0] rd, bit typed = 0,
                         logic [31:0] num = 0, logic [30:0] den = 1,
                         logic eq = 0, logic [1:0] st = ST_OK);
    row_t r;
    r.mode = m; r.ln = ln; r.ld = ld; r.rn = rn; r.rd = rd;
    r.typed = typed;
    r.res.num = num; r.res.den = den; r.res.eq = eq; r.res.st = st;
    table_q.push_back(r);
  endtask

  function automatic logic [31:0] pick_value(bit nonzero);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 60) - 30;
      3:       v = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff)
                   + $urandom_range(0, 2);
      4, 5:    v = $urandom >> $urandom_range(0, 31);
      6:       v = -($urandom >> $urandom_range(0, 31));
      default: v = $urandom;
    endcase
    if (nonzero && v == 0) v = 32'd1;
    return v;
  endfunction

  task automatic build_random;
    logic [31:0] ln, ld, rn, rd, k;
    logic [2:0]  m;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      m  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      ln = pick_value(0);
      ld = pick_value($urandom_range(0, 24) != 0);
      rn = pick_value(0);
      rd = pick_value($urandom_range(0, 24) != 0);
      // equal fractions under a small scale factor, some made unequal
      if ($urandom_range(0, 3) == 0) begin
        ln = $urandom_range(0, 2000) - 1000;
        ld = $urandom_range(1, 1000) * ($urandom_range(0, 1) ? 1 : -1);
        k  = $urandom_range(1, 50) * ($urandom_range(0, 1) ? 1 : -1);
        rn = ln * k;
        rd = ld * k;
        if ($urandom_range(0, 3) == 0) rn = rn + 1;
      end
      add_row(m, ln, ld, rn, rd);
    end
  endtask

  initial begin
    add_row(MODE_ADD, 1, 0, 1, 1, 1, 0, 1, 0, ST_ZERO);
    add_row(MODE_CMP, 1, 1, 1, 0, 1, 0, 1, 0, ST_ZERO);
    add_row(MODE_DIV, 3, 4, 0, -7, 1, 0, 1, 0, ST_ZERO);
    add_row(3'd5, 7, 3, 2, 9, 1, 0, 1, 0, ST_OK);
    add_row(3'd7, 32'h8000_0000, 0, 1, 0, 1, 0, 1, 0, ST_OK);
    add_row(MODE_ADD, 0, -5, 0, 3, 1, 0, 1, 0, ST_OK);
    add_row(MODE_ADD, 1, 2, 1, 3, 1, 5, 6, 0, ST_OK);
    add_row(MODE_SUB, 1, 2, 1, 2, 1, 0, 1, 0, ST_OK);
    add_row(MODE_MUL, 2, -4, 3, 9, 1, -1, 6, 0, ST_OK);
    add_row(MODE_DIV, -1, 2, -1, 4, 1, 2, 1, 0, ST_OK);
    add_row(MODE_CMP, 0, -5, 0, 3, 1, 0, 1, 1, ST_OK);
    add_row(MODE_CMP, 1, -2, -1, 2, 1, 0, 1, 1, ST_OK);
    add_row(MODE_CMP, 1, 2, -1, 2, 1, 0, 1, 0, ST_OK);
    add_row(MODE_MUL, 32'h8000_0000, 1, -1, 1, 1, 0, 1, 0, ST_OVF);
    add_row(MODE_MUL, 32'h8000_0000, 1, 1, 1, 1, 32'h8000_0000, 1, 0, ST_OK);
    add_row(MODE_DIV, 1, 32'h8000_0000, 1, 1, 1, 0, 1, 0, ST_OVF);
    add_row(MODE_ADD, 32'h7fff_ffff, 1, 1, 1, 1, 0, 1, 0, ST_OVF);
    add_row(MODE_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    add_row(MODE_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe);
    add_row(MODE_DIV, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
    add_row(MODE_CMP, 32'h8000_0000, 32'h8000_0000, -1, -1);
    add_row(MODE_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0001);
    build_random();
  end

  // --- sender: bursts with random gaps ----------------------------------------
  initial begin
    int burst_left, gap;
    row_t r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0; in_left_num = '0; in_left_den = '0;
    in_right_num = '0; in_right_den = '0;
    stim_done = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    while (table_q.size() != 0) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
      r = table_q.pop_front();
      in_mode <= r.mode;
      in_left_num <= r.ln;  in_left_den <= r.ld;
      in_right_num <= r.rn; in_right_den <= r.rd;
      in_valid <= 1'b1;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      // transfer taken at this edge
      expected_q.push_back(r.typed ? r.res
                           : predict_ratio(r.mode, r.ln, r.ld, r.rn, r.rd));
      accepted++;
      burst_left--;
      @(negedge clk);
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // --- receiver: own stall pattern, one long hold-off -----------------------
  initial begin
    int cyc;
    out_stall = 1'b0;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 20000) begin
        out_stall <= 1'b1;
        repeat (4000) @(negedge clk);
      end
      if ((cyc / 5000) % 3 == 0) out_stall <= 1'b0;
      else if ((cyc / 5000) % 3 == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 3) != 0);
    end
  end

  // --- result checker -------------------------------------------------------
  always @(posedge clk) begin
    ratio_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (out_result_num !== e.num) begin
          $error("result_num expected %0d got %0d", $signed(e.num),
                 $signed(out_result_num));
          errors++;
        end
        if (out_result_den !== e.den) begin
          $error("result_den expected %0d got %0d", e.den, out_result_den);
          errors++;
        end
        if (out_is_equal !== e.eq) begin
          $error("is_equal expected %0d got %0d", e.eq, out_is_equal);
          errors++;
        end
        if (out_status !== e.st) begin
          $error("status expected %0d got %0d", e.st, out_status);
          errors++;
        end
      end
    end
  end

  // --- watchdog: cycles without any transfer --------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("rational_arith_unit: mismatch");
      $finish;
    end
  end

  // --- end of run -----------------------------------------------------------
  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d items in all five modes plus unused codes, zero", accepted);
    $display("denominators, divide by zero and overflow; %0d results checked", checked);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("rational_arith_unit: match");
    end else begin
      $display("rational_arith_unit: mismatch");
    end
    $finish;
  end
endmodule
